@@ rtl/aptc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aptc_pkg: shared types and constants for the altitude PID thrust core
// Fixed-point widths, register indexes, sequencer states and the request and
// response structs of the shared multiplier and divider.
// ----------------------------------------------------------------------------
package aptc_pkg;

    // Data format
    localparam int DATA_WIDTH    = 32;   // signed data words
    localparam int FRAC_BITS     = 16;   // fraction bits of data and gains
    localparam int CFG_W         = 24;   // configuration registers
    localparam int TILT_W        = 15;   // tilt cosine, unsigned Q1.14
    localparam int TILT_ONE_BITS = 14;
    localparam int DT_W          = 16;   // time step, Q0.16
    localparam int DT_FRAC_BITS  = 16;
    localparam int ERR_W         = DATA_WIDTH + 1;
    localparam int INT_W         = 40;   // error integral
    localparam int INT_EXT_W     = 50;   // integral plus increment before saturation
    localparam int SUM_W         = 49;   // saturated term sum
    localparam int ACC_W         = 51;   // term accumulator
    localparam int SUM_MAG_W     = SUM_W - 1;
    localparam int LIMIT_W       = 40;

    // Shared multiplier: 48-bit magnitude times 24-bit factor, two 24-bit chunks
    localparam int MUL_A_W     = 48;
    localparam int MUL_B_W     = 24;
    localparam int MUL_CHUNK_W = 24;
    localparam int PROD_W      = 64;
    localparam int P_W         = PROD_W + 1;
    localparam int PROD_HI_W   = PROD_W - FRAC_BITS;

    // Shared divider: 64-bit dividend, 16-bit divisor, 44 quotient bits
    localparam int DIV_N_W     = 64;
    localparam int DIV_D_W     = 16;
    localparam int DIV_Q_W     = 44;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_CYCLES  = DIV_Q_W / DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam int CFG_IDX_W   = 3;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_GAIN     = 3'd0,
        REG_VEL_GAIN     = 3'd1,
        REG_INT_GAIN     = 3'd2,
        REG_VEHICLE_MASS = 3'd3,
        REG_ASCENT_LIMIT = 3'd4,
        REG_GRAVITY      = 3'd5
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] MASS_RST    = 24'd65536;
    localparam logic [CFG_W-1:0] ASCENT_RST  = 24'd6553600;
    localparam logic [CFG_W-1:0] GRAVITY_RST = 24'd642908;

    localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    localparam logic signed [ACC_W-1:0] SUM_MAX =
        {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SUM_MIN = -SUM_MAX;

    localparam logic [LIMIT_W-1:0] NO_LIMIT = {LIMIT_W{1'b1}};

    localparam logic [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [CFG_W-1:0] pos_gain;
        logic [CFG_W-1:0] vel_gain;
        logic [CFG_W-1:0] int_gain;
        logic [CFG_W-1:0] vehicle_mass;
        logic [CFG_W-1:0] ascent_limit;
        logic [CFG_W-1:0] gravity_accel;
    } cfg_regs_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] p;       // two's complement product
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] n;
        logic [DIV_D_W-1:0] d;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               ovf;  // quotient does not fit DIV_Q_W bits
        logic [DIV_Q_W-1:0] q;
    } div_rsp_t;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_SIGN
    } mul_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_IWAIT,
        ST_PWAIT,
        ST_DWAIT,
        ST_KWAIT,
        ST_SAT,
        ST_AGO,
        ST_AWAIT,
        ST_LWAIT,
        ST_CLAMP,
        ST_MWAIT,
        ST_FIN
    } ctl_state_t;

endpackage

@@ rtl/aptc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aptc_cfg_regs: configuration register file
// Six 24-bit registers written through a valid/ready port; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module aptc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [aptc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aptc_pkg::CFG_W-1:0]         cfg_data,
    output aptc_pkg::cfg_regs_t                cfg
);
    import aptc_pkg::*;

    cfg_regs_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_gain      <= '0;
            cfg_reg.vel_gain      <= '0;
            cfg_reg.int_gain      <= '0;
            cfg_reg.vehicle_mass  <= MASS_RST;
            cfg_reg.ascent_limit  <= ASCENT_RST;
            cfg_reg.gravity_accel <= GRAVITY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_POS_GAIN:     cfg_reg.pos_gain      <= cfg_data;
                REG_VEL_GAIN:     cfg_reg.vel_gain      <= cfg_data;
                REG_INT_GAIN:     cfg_reg.int_gain      <= cfg_data;
                REG_VEHICLE_MASS: cfg_reg.vehicle_mass  <= cfg_data;
                REG_ASCENT_LIMIT: cfg_reg.ascent_limit  <= cfg_data;
                REG_GRAVITY:      cfg_reg.gravity_accel <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule

@@ rtl/aptc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aptc_mul: shared sign-magnitude multiplier
// One 24x24 multiplier, used for the low then the high chunk of the
// magnitude; the sign is applied in a third step.
// ----------------------------------------------------------------------------
module aptc_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  aptc_pkg::mul_req_t  req,
    output aptc_pkg::mul_rsp_t  rsp
);
    import aptc_pkg::*;

    mul_phase_t               phase_reg, phase_next;
    logic                     done_reg;
    logic [MUL_A_W-1:0]       a_reg;
    logic [MUL_B_W-1:0]       b_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [P_W-1:0]           p_reg;
    logic [MUL_CHUNK_W-1:0]   chunk;
    logic [2*MUL_CHUNK_W-1:0] part;

    assign chunk = (phase_reg == MP_LO) ? a_reg[MUL_CHUNK_W-1:0]
                                        : a_reg[MUL_A_W-1:MUL_CHUNK_W];
    assign part  = chunk * b_reg;

    assign rsp.done = done_reg;
    assign rsp.p    = p_reg;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            MP_IDLE: if (req.start) phase_next = MP_LO;
            MP_LO:   phase_next = MP_HI;
            MP_HI:   phase_next = MP_SIGN;
            MP_SIGN: phase_next = MP_IDLE;
            default: phase_next = MP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MP_SIGN);
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            MP_IDLE:
            begin
                if (req.start)
                begin
                    a_reg   <= req.a;
                    b_reg   <= req.b;
                    neg_reg <= req.neg;
                end
            end
            MP_LO:   acc_reg <= {{(PROD_W-2*MUL_CHUNK_W){1'b0}}, part};
            MP_HI:   acc_reg <= acc_reg + {part[PROD_W-MUL_CHUNK_W-1:0], {MUL_CHUNK_W{1'b0}}};
            MP_SIGN: p_reg   <= neg_reg ? ({P_W{1'b0}} - {1'b0, acc_reg}) : {1'b0, acc_reg};
            default: ;
        endcase
    end

endmodule

@@ rtl/aptc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aptc_div: shared unsigned restoring divider
// 44 quotient bits, four per cycle, narrow 16-bit divisor. Flags overflow
// when the quotient would need more than 44 bits.
// ----------------------------------------------------------------------------
module aptc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  aptc_pkg::div_req_t  req,
    output aptc_pkg::div_rsp_t  rsp
);
    import aptc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   div_reg;
    logic [DIV_Q_W-1:0]   num_reg;
    logic [DIV_D_W-1:0]   rem_step;
    logic [DIV_Q_W-1:0]   num_step;
    logic                 last;

    assign last = (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.q    = num_reg;

    // four restoring steps; quotient bits shift in as dividend bits leave
    always_comb
    begin
        logic [DIV_D_W-1:0] r;
        logic [DIV_Q_W-1:0] n;
        logic [DIV_D_W:0]   r_ext;
        logic [DIV_D_W:0]   r_diff;
        r = rem_reg;
        n = num_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r_ext  = {r, n[DIV_Q_W-1]};
            r_diff = r_ext - {1'b0, div_reg};
            n      = {n[DIV_Q_W-2:0], 1'b0};
            if (r_ext >= {1'b0, div_reg})
            begin
                r    = r_diff[DIV_D_W-1:0];
                n[0] = 1'b1;
            end
            else
            begin
                r = r_ext[DIV_D_W-1:0];
            end
        end
        rem_step = r;
        num_step = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            ovf_reg <= (req.n[DIV_N_W-1:DIV_Q_W] >=
                        {{(DIV_N_W-DIV_Q_W-DIV_D_W){1'b0}}, req.d});
            rem_reg <= req.n[DIV_Q_W+DIV_D_W-1:DIV_Q_W];
            num_reg <= req.n[DIV_Q_W-1:0];
            div_reg <= req.d;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            num_reg <= num_step;
        end
    end

endmodule

@@ rtl/altitude_pid_thrust_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_pid_thrust_core: vertical PID step with feed-forward to thrust
// Sequencer around one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one control step per
//   transaction: setpoints, measurements, feed-forward, tilt cosine and time
//   step. Output channel (out_valid/out_ready) returns thrust and the
//   limited flag, one transaction per input transaction, in order.
//   Config channel (cfg_valid/cfg_ready) writes the six gain/limit registers,
//   always ready; the user writes it only while the core is idle (unenforced).
// Sequence:
//   Each step takes five products through the shared 24x24 multiplier and
//   two 44-bit divisions through the shared divider at 4 quotient bits per
//   cycle; with a zero tilt cosine the divisions and the last product are
//   skipped. in_ready rises in the same cycle as out_valid, so a new step is
//   taken only after the previous result has reached the output register.
// Reset:
//   rst_n clears the error integral and loads the register defaults.
// Backpressure:
//   A finished result sits in the output register; a new transaction is
//   taken meanwhile, and its result waits in the final state until the
//   output register is free.
// ----------------------------------------------------------------------------
module altitude_pid_thrust_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // input channel
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [aptc_pkg::DATA_WIDTH-1:0]   pos_cmd,
    input  logic signed [aptc_pkg::DATA_WIDTH-1:0]   vel_cmd,
    input  logic signed [aptc_pkg::DATA_WIDTH-1:0]   pos_now,
    input  logic signed [aptc_pkg::DATA_WIDTH-1:0]   vel_now,
    input  logic signed [aptc_pkg::DATA_WIDTH-1:0]   accel_ff,
    input  logic        [aptc_pkg::TILT_W-1:0]       tilt_cosine,
    input  logic        [aptc_pkg::DT_W-1:0]         time_step,
    // output channel
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [aptc_pkg::DATA_WIDTH-1:0]   thrust,
    output logic                                     limited,
    // configuration channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [aptc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic        [aptc_pkg::CFG_W-1:0]        cfg_data
);
    import aptc_pkg::*;

    cfg_regs_t  cfg;
    mul_req_t   mul_req;
    mul_rsp_t   mul_rsp;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    ctl_state_t state_reg, state_next;

    // step operands
    logic [ERR_W-1:0]      zerr_reg;
    logic [ERR_W-1:0]      verr_reg;
    logic [TILT_W-1:0]     tilt_reg;
    logic [DT_W-1:0]       dt_reg;
    logic [ACC_W-1:0]      sum_reg;
    logic [INT_W-1:0]      integral_reg;
    logic [DIV_Q_W-1:0]    quot_reg;
    logic                  aovf_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic                  lim_reg;

    // output register
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] thrust_reg;
    logic                  limited_reg;

    // datapath
    logic [ERR_W-1:0]      zerr_mag;
    logic [ERR_W-1:0]      verr_mag;
    logic [INT_W-1:0]      int_mag;
    logic signed [P_W-1:0] term_f;
    logic signed [P_W-1:0] term_dt;
    logic [INT_EXT_W-1:0]  int_sum;
    logic                  int_fits;
    logic [INT_W-1:0]      int_sat;
    logic [ACC_W-1:0]      sum_add;
    logic [ACC_W-1:0]      sum_sat;
    logic [ACC_W-1:0]      sum_neg;
    logic [SUM_MAG_W-1:0]  sum_mag;
    logic                  acc_neg;
    logic                  over;
    logic [LIMIT_W-1:0]    clamp_mag;
    logic [PROD_HI_W-1:0]  prod_hi;
    logic                  big_pos;
    logic                  big_neg;
    logic [DATA_WIDTH-1:0] thrust_fin;
    logic                  limited_fin;
    logic                  out_free;
    logic                  accept;
    logic                  fin_load;

    aptc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aptc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    aptc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign thrust    = thrust_reg;
    assign limited   = limited_reg;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign fin_load = (state_reg == ST_FIN) && out_free;

    // magnitudes fed to the multiplier
    assign zerr_mag = zerr_reg[ERR_W-1] ? ({ERR_W{1'b0}} - zerr_reg) : zerr_reg;
    assign verr_mag = verr_reg[ERR_W-1] ? ({ERR_W{1'b0}} - verr_reg) : verr_reg;
    assign int_mag  = integral_reg[INT_W-1] ? ({INT_W{1'b0}} - integral_reg) : integral_reg;

    // floor shifts of the signed product
    assign term_f  = $signed(mul_rsp.p) >>> FRAC_BITS;
    assign term_dt = $signed(mul_rsp.p) >>> DT_FRAC_BITS;

    // saturating integral update
    assign int_sum  = {{(INT_EXT_W-INT_W){integral_reg[INT_W-1]}}, integral_reg}
                    + term_dt[INT_EXT_W-1:0];
    assign int_fits = (&int_sum[INT_EXT_W-1:INT_W-1]) | ~(|int_sum[INT_EXT_W-1:INT_W-1]);
    assign int_sat  = int_fits ? int_sum[INT_W-1:0]
                               : (int_sum[INT_EXT_W-1] ? INT_MIN : INT_MAX);

    // term accumulation and symmetric saturation
    assign sum_add = sum_reg + term_f[ACC_W-1:0];
    assign sum_sat = ($signed(sum_reg) > SUM_MAX) ? SUM_MAX :
                     (($signed(sum_reg) < SUM_MIN) ? SUM_MIN : sum_reg);
    assign sum_neg = {ACC_W{1'b0}} - sum_reg;
    assign sum_mag = sum_reg[ACC_W-1] ? sum_neg[SUM_MAG_W-1:0] : sum_reg[SUM_MAG_W-1:0];
    assign acc_neg = sum_reg[ACC_W-1];

    // acceleration clamp
    assign over      = aovf_reg || (quot_reg > {{(DIV_Q_W-LIMIT_W){1'b0}}, limit_reg});
    assign clamp_mag = over ? limit_reg : quot_reg[LIMIT_W-1:0];

    // thrust = -mass * acc, saturated to the data width
    assign prod_hi = mul_rsp.p[PROD_W-1:FRAC_BITS];
    assign big_neg = |prod_hi[PROD_HI_W-1:DATA_WIDTH-1];
    assign big_pos = (|prod_hi[PROD_HI_W-1:DATA_WIDTH])
                   || (prod_hi[DATA_WIDTH-1] && (|prod_hi[DATA_WIDTH-2:0]));

    always_comb
    begin
        if (tilt_reg == '0)
        begin
            // no vertical authority: drive to the rail opposite the demand
            thrust_fin  = acc_neg ? D_MAX : D_MIN;
            limited_fin = 1'b1;
        end
        else if (acc_neg)
        begin
            thrust_fin  = big_neg ? D_MAX : prod_hi[DATA_WIDTH-1:0];
            limited_fin = lim_reg | big_neg;
        end
        else
        begin
            thrust_fin  = big_pos ? D_MIN : ({DATA_WIDTH{1'b0}} - prod_hi[DATA_WIDTH-1:0]);
            limited_fin = lim_reg | big_pos;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_IWAIT;
            ST_IWAIT: if (mul_rsp.done) state_next = ST_PWAIT;
            ST_PWAIT: if (mul_rsp.done) state_next = ST_DWAIT;
            ST_DWAIT: if (mul_rsp.done) state_next = ST_KWAIT;
            ST_KWAIT: if (mul_rsp.done) state_next = ST_SAT;
            ST_SAT:   state_next = ST_AGO;
            ST_AGO:   state_next = (tilt_reg == '0) ? ST_FIN : ST_AWAIT;
            ST_AWAIT: if (div_rsp.done) state_next = ST_LWAIT;
            ST_LWAIT: if (div_rsp.done) state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_MWAIT;
            ST_MWAIT: if (mul_rsp.done) state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: unit requests and input handshake
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        mul_req.start = 1'b0;
        mul_req.neg   = zerr_reg[ERR_W-1];
        mul_req.a     = {{(MUL_A_W-ERR_W){1'b0}}, zerr_mag};
        mul_req.b     = cfg.pos_gain;
        div_req.start = 1'b0;
        div_req.n     = {{(DIV_N_W-SUM_MAG_W-TILT_ONE_BITS){1'b0}}, sum_mag,
                         {TILT_ONE_BITS{1'b0}}};
        div_req.d     = {{(DIV_D_W-TILT_W){1'b0}}, tilt_reg};
        case (state_reg)
            ST_LOAD:
            begin
                // integral increment: zerr * dt
                mul_req.start = 1'b1;
                mul_req.b     = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
            end
            ST_IWAIT:
            begin
                // P term
                mul_req.start = mul_rsp.done;
            end
            ST_PWAIT:
            begin
                // D term
                mul_req.start = mul_rsp.done;
                mul_req.neg   = verr_reg[ERR_W-1];
                mul_req.a     = {{(MUL_A_W-ERR_W){1'b0}}, verr_mag};
                mul_req.b     = cfg.vel_gain;
            end
            ST_DWAIT:
            begin
                // I term on the updated integral
                mul_req.start = mul_rsp.done;
                mul_req.neg   = integral_reg[INT_W-1];
                mul_req.a     = {{(MUL_A_W-INT_W){1'b0}}, int_mag};
                mul_req.b     = cfg.int_gain;
            end
            ST_AGO:
            begin
                // |sum| * 2^14 / tilt
                div_req.start = (tilt_reg != '0);
            end
            ST_AWAIT:
            begin
                // ascent_limit * 2^16 / dt
                div_req.start = div_rsp.done;
                div_req.n     = {{(DIV_N_W-CFG_W-DT_FRAC_BITS){1'b0}}, cfg.ascent_limit,
                                 {DT_FRAC_BITS{1'b0}}};
                div_req.d     = dt_reg;
            end
            ST_CLAMP:
            begin
                // |acc| * mass
                mul_req.start = 1'b1;
                mul_req.neg   = 1'b0;
                mul_req.a     = {{(MUL_A_W-LIMIT_W){1'b0}}, clamp_mag};
                mul_req.b     = cfg.vehicle_mass;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            integral_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_IWAIT) && mul_rsp.done)
                integral_reg <= int_sat;
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zerr_reg <= {pos_cmd[DATA_WIDTH-1], pos_cmd} - {pos_now[DATA_WIDTH-1], pos_now};
            verr_reg <= {vel_cmd[DATA_WIDTH-1], vel_cmd} - {vel_now[DATA_WIDTH-1], vel_now};
            sum_reg  <= {{(ACC_W-DATA_WIDTH){accel_ff[DATA_WIDTH-1]}}, accel_ff}
                      - {{(ACC_W-CFG_W){1'b0}}, cfg.gravity_accel};
            tilt_reg <= tilt_cosine;
            dt_reg   <= time_step;
        end
        if (((state_reg == ST_PWAIT) || (state_reg == ST_DWAIT) ||
             (state_reg == ST_KWAIT)) && mul_rsp.done)
            sum_reg <= sum_add;
        if (state_reg == ST_SAT)
            sum_reg <= sum_sat;
        if ((state_reg == ST_AWAIT) && div_rsp.done)
        begin
            quot_reg <= div_rsp.q;
            aovf_reg <= div_rsp.ovf;
        end
        if ((state_reg == ST_LWAIT) && div_rsp.done)
            limit_reg <= (dt_reg == '0) ? NO_LIMIT : div_rsp.q[LIMIT_W-1:0];
        if (state_reg == ST_CLAMP)
            lim_reg <= over;
        if (fin_load)
        begin
            thrust_reg  <= thrust_fin;
            limited_reg <= limited_fin;
        end
    end

endmodule

@@ tb/altitude_pid_thrust_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_pid_thrust_core_tb: self-checking bench for the altitude PID core
// Drives control steps over the input channel and checks every thrust
// transaction against a cycle-free fixed-point predictor held in the bench.
// The predictor tracks the error integral and the register file. Traffic
// runs with random sender and receiver idling, through directed corner
// cases, an integral windup run and randomized register settings.
// ----------------------------------------------------------------------------
module altitude_pid_thrust_core_tb;
    import aptc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 60;     // wait after the final drain before the verdict

    // Indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic [CFG_W-1:0]             REG_FULL = 24'hFF_FFFF;
    localparam logic [TILT_W-1:0]            TILT_ONE = 15'd16384;

    // Predictor saturation bounds
    localparam longint          INTEG_MAX   = (64'sd1 <<< 39) - 1;
    localparam longint          INTEG_MIN   = -INTEG_MAX - 1;
    localparam longint          TERM_SUM_MAX = (64'sd1 <<< 48) - 1;
    localparam longint          ACC_UNBOUND = (64'sd1 <<< 40) - 1;
    localparam longint unsigned POS_MAG_MAX = 64'h7FFF_FFFF;
    localparam longint unsigned NEG_MAG_MAX = 64'h8000_0000;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] pos_cmd;
        logic signed [DATA_WIDTH-1:0] vel_cmd;
        logic signed [DATA_WIDTH-1:0] pos_now;
        logic signed [DATA_WIDTH-1:0] vel_now;
        logic signed [DATA_WIDTH-1:0] accel_ff;
        logic [TILT_W-1:0]            tilt_cosine;
        logic [DT_W-1:0]              time_step;
    } ctl_step_t;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] thrust;
        logic                         limited;
    } thrust_res_t;

    // ------------------------------------------------------------------------
    // DUT signals, bench-driven inputs all known from time zero
    // ------------------------------------------------------------------------
    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic signed [DATA_WIDTH-1:0] pos_cmd     = '0;
    logic signed [DATA_WIDTH-1:0] vel_cmd     = '0;
    logic signed [DATA_WIDTH-1:0] pos_now     = '0;
    logic signed [DATA_WIDTH-1:0] vel_now     = '0;
    logic signed [DATA_WIDTH-1:0] accel_ff    = '0;
    logic [TILT_W-1:0]            tilt_cosine = '0;
    logic [DT_W-1:0]              time_step   = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic signed [DATA_WIDTH-1:0] thrust;
    logic                         limited;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index   = '0;
    logic [CFG_W-1:0]             cfg_data    = '0;

    // Bench-side copy of the register file and the integrator
    logic [CFG_W-1:0] kp_reg      = 24'd0;
    logic [CFG_W-1:0] kd_reg      = 24'd0;
    logic [CFG_W-1:0] ki_reg      = 24'd0;
    logic [CFG_W-1:0] mass_reg    = 24'd65536;
    logic [CFG_W-1:0] ascent_reg  = 24'd6553600;
    logic [CFG_W-1:0] gravity_reg = 24'd642908;
    longint           err_integral = 0;

    thrust_res_t pending_thrust_q[$];   // predicted results, oldest first
    int          mismatches     = 0;
    int          stall_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    always #(CLK_HALF) clk = ~clk;

    altitude_pid_thrust_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pos_cmd     (pos_cmd),
        .vel_cmd     (vel_cmd),
        .pos_now     (pos_now),
        .vel_now     (vel_now),
        .accel_ff    (accel_ff),
        .tilt_cosine (tilt_cosine),
        .time_step   (time_step),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .thrust      (thrust),
        .limited     (limited),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Thrust predictor. Updates the integral, so call once per accepted step.
    // Signed products stay below 2^63 and the mass product below 2^64, so plain
    // longint math with arithmetic shifts gives the floor-scaled terms directly.
    // ------------------------------------------------------------------------
    function automatic thrust_res_t compute_thrust(input ctl_step_t s);
        longint          zerr;
        longint          verr;
        longint          integ_next;
        longint          p_term;
        longint          d_term;
        longint          i_term;
        longint          term_sum;
        longint          acc;
        longint          acc_bound;
        longint unsigned acc_mag;
        longint unsigned thrust_mag;
        thrust_res_t     r;
        zerr = longint'(s.pos_cmd) - longint'(s.pos_now);
        verr = longint'(s.vel_cmd) - longint'(s.vel_now);

        // Integral of position error, scaled by the Q0.16 step, 40-bit saturated
        integ_next = err_integral + ((zerr * longint'(s.time_step)) >>> DT_FRAC_BITS);
        if (integ_next > INTEG_MAX)
            integ_next = INTEG_MAX;
        else if (integ_next < INTEG_MIN)
            integ_next = INTEG_MIN;
        err_integral = integ_next;

        p_term = (zerr * longint'(kp_reg)) >>> FRAC_BITS;
        d_term = (verr * longint'(kd_reg)) >>> FRAC_BITS;
        i_term = (err_integral * longint'(ki_reg)) >>> FRAC_BITS;
        term_sum = p_term + d_term + i_term + longint'(s.accel_ff) - longint'(gravity_reg);
        if (term_sum > TERM_SUM_MAX)
            term_sum = TERM_SUM_MAX;
        else if (term_sum < -TERM_SUM_MAX)
            term_sum = -TERM_SUM_MAX;

        r.limited = 1'b0;
        if (s.tilt_cosine == '0) begin
            // No tilt compensation possible: slam the output
            r.thrust  = (term_sum >= 0) ? WORD_MIN : WORD_MAX;
            r.limited = 1'b1;
        end
        else begin
            acc = (term_sum * longint'(TILT_ONE)) / longint'(s.tilt_cosine);
            if (s.time_step == '0)
                acc_bound = ACC_UNBOUND;
            else
                acc_bound = longint'({ascent_reg, 16'h0000}) / longint'(s.time_step);
            if (acc > acc_bound) begin
                acc       = acc_bound;
                r.limited = 1'b1;
            end
            if (acc < -acc_bound) begin
                acc       = -acc_bound;
                r.limited = 1'b1;
            end
            acc_mag    = (acc < 0) ? longint'(-acc) : longint'(acc);
            thrust_mag = (acc_mag * longint'(mass_reg)) >> FRAC_BITS;
            // NED: thrust points against the commanded acceleration
            if (acc < 0) begin
                if (thrust_mag > POS_MAG_MAX) begin
                    r.thrust  = WORD_MAX;
                    r.limited = 1'b1;
                end
                else
                    r.thrust = 32'(thrust_mag);
            end
            else begin
                if (thrust_mag > NEG_MAG_MAX) begin
                    r.thrust  = WORD_MIN;
                    r.limited = 1'b1;
                end
                else
                    r.thrust = 32'(-longint'(thrust_mag));
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------------
    function automatic ctl_step_t make_step(
        input logic signed [DATA_WIDTH-1:0] pc, vc, pn, vn, ff,
        input logic [TILT_W-1:0] tc,
        input logic [DT_W-1:0]   dt
    );
        ctl_step_t s;
        s.pos_cmd     = pc;
        s.vel_cmd     = vc;
        s.pos_now     = pn;
        s.vel_now     = vn;
        s.accel_ff    = ff;
        s.tilt_cosine = tc;
        s.time_step   = dt;
        return s;
    endfunction

    // Mostly values within +/-100 m, some full-range words and the extremes
    function automatic logic signed [DATA_WIDTH-1:0] rand_data_word();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return WORD_MAX;
                    1:       return WORD_MIN;
                    2:       return '0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return 32'($urandom_range(0, 13107200)) - 32'sd6553600;
        endcase
    endfunction

    function automatic logic [TILT_W-1:0] rand_tilt();
        case ($urandom_range(19))
            0:       return '0;
            1:       return TILT_ONE;
            2:       return 15'h7FFF;
            3:       return 15'd1;
            4, 5, 6: return 15'($urandom_range(1, 32767));
            default: return 15'($urandom_range(11000, 16384));
        endcase
    endfunction

    // Typical loop periods of 1 to 50 ms, plus the corners
    function automatic logic [DT_W-1:0] rand_time_step();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4, 5: return 16'($urandom);
            default: return 16'($urandom_range(65, 3277));
        endcase
    endfunction

    function automatic ctl_step_t rand_step();
        return make_step(rand_data_word(), rand_data_word(), rand_data_word(),
                         rand_data_word(), rand_data_word(), rand_tilt(),
                         rand_time_step());
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return REG_FULL;
            2, 3:    return 24'($urandom_range(0, 24'h08_0000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_mass();
        case ($urandom_range(5))
            0:       return 24'd1;
            1:       return REG_FULL;
            2, 3:    return 24'($urandom_range(24'h00_8000, 24'h05_0000));
            default: return 24'($urandom_range(1, 24'hFF_FFFF));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_ascent();
        case ($urandom_range(5))
            0:       return '0;
            1:       return REG_FULL;
            2, 3:    return 24'($urandom_range(24'h01_0000, 24'h0A_0000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_gravity();
        case ($urandom_range(3))
            0:       return '0;
            1:       return REG_FULL;
            2:       return 24'd642908;
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks. Each starts and ends on a falling edge; handshakes are
    // sampled right after the rising edge, before the DUT's flops update.
    // ------------------------------------------------------------------------
    task automatic send_step(input ctl_step_t s);
        // Random sender gap before the transaction
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        pos_cmd     = s.pos_cmd;
        vel_cmd     = s.vel_cmd;
        pos_now     = s.pos_now;
        vel_now     = s.vel_now;
        accel_ff    = s.accel_ff;
        tilt_cosine = s.tilt_cosine;
        time_step   = s.time_step;
        in_valid    = 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        pending_thrust_q.push_back(compute_thrust(s));
        @(negedge clk);
    endtask

    // Hold the sender until every predicted result has been seen
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_thrust_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_POS_GAIN:     kp_reg      = val;
            REG_VEL_GAIN:     kd_reg      = val;
            REG_INT_GAIN:     ki_reg      = val;
            REG_VEHICLE_MASS: mass_reg    = val;
            REG_ASCENT_LIMIT: ascent_reg  = val;
            REG_GRAVITY:      gravity_reg = val;
            default:          ;   // spare index, dropped
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] kp, kd, ki, mass, ascent, grav);
        write_reg(REG_POS_GAIN, kp);
        write_reg(REG_VEL_GAIN, kd);
        write_reg(REG_INT_GAIN, ki);
        write_reg(REG_VEHICLE_MASS, mass);
        write_reg(REG_ASCENT_LIMIT, ascent);
        write_reg(REG_GRAVITY, grav);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values: zero gains, unit mass, so thrust tracks gravity
    // and feed-forward; covers zero tilt both ways, zero step and tilt > 1.
    task automatic test_reset_defaults();
        send_step(make_step(0, 0, 0, 0, 0, TILT_ONE, 16'd1));
        send_step(make_step(0, 0, 0, 0, 0, 15'd0, 16'd100));
        send_step(make_step(0, 0, 0, 0, WORD_MAX, 15'd0, 16'd100));
        send_step(make_step(0, 0, 0, 0, WORD_MIN, TILT_ONE, 16'd0));
        send_step(make_step(0, 0, 0, 0, rand_data_word(), 15'h7FFF, 16'hFFFF));
        send_step(make_step(0, 0, 0, 0, WORD_MAX, 15'd1, 16'hFFFF));
    endtask

    // Full-scale registers (but zero gravity) and data words, alternating bit
    // patterns, then zero mass with a zero ascent limit, then a minimal mass.
    task automatic test_register_extremes();
        drain_results();
        load_regs(REG_FULL, REG_FULL, REG_FULL, REG_FULL, REG_FULL, '0);
        // Spare indexes must not alias onto any real register
        write_reg(REG_SPARE_LO, 24'h00_0000);
        write_reg(REG_SPARE_HI, 24'h00_0001);
        send_step(make_step(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 15'd1, 16'hFFFF));
        send_step(make_step(WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 15'd1, 16'hFFFF));
        send_step(make_step(0, 0, 0, 0, 0, TILT_ONE, 16'd1));
        send_step(make_step(0, 0, 0, 0, 0, 15'd0, 16'd0));
        send_step(make_step(0, 0, 0, 0, 0, TILT_ONE, 16'd0));
        send_step(make_step(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                            32'shAAAA_AAAA, 32'sh5555_5555, 15'h5555, 16'hAAAA));
        send_step(make_step(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                            32'sh5555_5555, 32'shAAAA_AAAA, 15'h2AAA, 16'h5555));

        drain_results();
        load_regs('0, '0, '0, '0, '0, REG_FULL);
        send_step(make_step(0, 0, 0, 0, 32'sh0100_0000, TILT_ONE, 16'd655));
        send_step(make_step(0, 0, 0, 0, 0, 15'd0, 16'd655));

        drain_results();
        load_regs(24'h01_0000, 24'h00_8000, 24'h00_0100, 24'd1, REG_FULL, 24'd642908);
        send_step(make_step(32'sh0064_0000, 0, 0, 32'shFFFF_0000, 0, TILT_ONE, 16'd66));
        send_step(make_step(32'shFF9C_0000, 0, 0, 32'sh0001_0000, 0, 15'd15000, 16'd66));
    endtask

    // Mixed random steps under one random register setting; now and then the
    // sender holds off until the pipeline is empty.
    task automatic test_random_traffic(input int n_steps);
        drain_results();
        load_regs(rand_gain(), rand_gain(), rand_gain(), rand_mass(), rand_ascent(),
                  rand_gravity());
        repeat (n_steps) begin
            if ($urandom_range(39) == 0)
                drain_results();
            send_step(rand_step());
        end
    endtask

    // Sustained near-full-scale position error drives the 40-bit integral
    // into positive saturation, then the opposite error walks it down into
    // negative saturation. A tenth of the steps are plain noise.
    task automatic test_integral_windup(input int n_up, input int n_down);
        ctl_step_t s;
        int        k;
        drain_results();
        load_regs(rand_gain(), rand_gain(), 24'($urandom_range(1, 24'h04_0000)),
                  rand_mass(), rand_ascent(), rand_gravity());
        for (k = 0; k < n_up + n_down; k++) begin
            s = rand_step();
            if ($urandom_range(9) != 0) begin
                if (k < n_up) begin
                    s.pos_cmd = {16'h7FFF, 16'($urandom)};
                    s.pos_now = {16'h8000, 16'($urandom)};
                end
                else begin
                    s.pos_cmd = {16'h8000, 16'($urandom)};
                    s.pos_now = {16'h7FFF, 16'($urandom)};
                end
                s.time_step = 16'hFFFF - 16'($urandom_range(255));
                if (s.tilt_cosine == '0)
                    s.tilt_cosine = TILT_ONE;
            end
            send_step(s);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random backpressure, changed on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------------
    // Result checker: every output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        thrust_res_t want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pending_thrust_q.size() == 0) begin
                $error("unexpected result transaction: thrust %0d limited %0b",
                       thrust, limited);
                mismatches++;
            end
            else begin
                want = pending_thrust_q.pop_front();
                if (thrust !== want.thrust) begin
                    $error("thrust: expected %0d, actual %0d", want.thrust, thrust);
                    mismatches++;
                end
                if (limited !== want.limited) begin
                    $error("limited: expected %0b, actual %0b", want.limited, limited);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no transaction on any channel means a hang
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
            (cfg_valid && cfg_ready === 1'b1) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Sender idles lightly, receiver stalls hard
        set_idling(20, 60);
        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(145);
        test_random_traffic(145);

        // Sender idles hard, receiver stalls lightly
        set_idling(60, 20);
        test_integral_windup(150, 300);
        test_random_traffic(145);

        // Back to back, no idling on either side
        set_idling(0, 0);
        test_random_traffic(145);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
